/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MET_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MET_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/met_pkg.sv */
// ---------------------------------------------------------------------------
// met_pkg
// Constants, sequencer states and shared types of the minimum-error
// threshold block.
// ---------------------------------------------------------------------------
`default_nettype none

package met_pkg;

  // Default configuration
  localparam int NUM_BINS_DEF      = 256;
  localparam int COUNT_BITS_DEF    = 24;
  localparam int LOG_FRAC_BITS_DEF = 16;
  localparam int MUL_W_DEF         = 49;

  // Fixed port widths
  localparam int BIN_COUNT_W = 24;
  localparam int THR_W       = 8;
  localparam int COLOR_W     = 16;

  // Multiplier digit width (bits of the second operand per cycle)
  localparam int DIG_W = 8;

  // Mantissa width of the log unit
  localparam int MANT_W = 32;

  // Sequencer states
  typedef enum logic [4:0] {
    S_LOAD,
    S_FETCH,
    S_MUL_HJ,
    S_MUL_HJJ,
    S_ACC,
    S_CHK1,
    S_MUL_NQ1,
    S_MUL_SS1,
    S_MUL_NQ2,
    S_MUL_SS2,
    S_CHK2,
    S_LOG_NORM,
    S_LOG_SQ,
    S_MUL_NL,
    S_CMP,
    S_NEXT,
    S_OUT
  } met_state_t;

  // Multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } met_mul_sts_t;

endpackage

`default_nettype wire

/* rtl/minimum_error_threshold_top.sv */
// ---------------------------------------------------------------------------
// minimum_error_threshold_top
// Minimum-error gray threshold: stores a histogram, then scores every split
// with fixed-point base-2 logs and reports the first best split.
// ---------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | bin_count, last_bin
//   out     | out_valid / out_stall| threshold, threshold_color, found
//
// Each bin item is taken while in_stall is low. The item with last_bin (or
// the final bin) starts the search, during which in_stall stays high. The
// search runs through one digit-serial multiplier (8 bits a cycle); a valid
// split costs four logs of 16 squarings each. Reset is synchronous; it
// empties the histogram position and the total. The result waits in an
// output register; a full register holds the search at its last step until
// out_stall drops.
`default_nettype none
`include "assert_macros.svh"

module minimum_error_threshold_top #(
  parameter int NUM_BINS      = met_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS    = met_pkg::COUNT_BITS_DEF,
  parameter int LOG_FRAC_BITS = met_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [met_pkg::BIN_COUNT_W-1:0] bin_count,
  input  wire logic                            last_bin,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [met_pkg::THR_W-1:0]       threshold,
  output logic      [met_pkg::COLOR_W-1:0]     threshold_color,
  output logic                                 found
);
  import met_pkg::*;

  localparam int IB  = $clog2(NUM_BINS);
  localparam int CB  = COUNT_BITS;
  localparam int FB  = LOG_FRAC_BITS;
  localparam int NW  = CB + IB;
  localparam int SW  = NW + IB;
  localparam int QW  = NW + 2 * IB;
  localparam int DW  = NW + QW;
  localparam int EW  = $clog2(DW);
  localparam int LW  = EW + FB;
  localparam int MW  = (QW > MANT_W) ? QW : MANT_W;
  localparam int PW  = 2 * MW;
  localparam int AW  = NW + LW + 3;
  localparam int KW  = $clog2(FB);
  localparam int CIN = (CB < BIN_COUNT_W) ? CB : BIN_COUNT_W;

  // Log operand selection
  localparam logic [1:0] LOG_D1 = 2'd0;
  localparam logic [1:0] LOG_D2 = 2'd1;
  localparam logic [1:0] LOG_N1 = 2'd2;
  localparam logic [1:0] LOG_N2 = 2'd3;

  met_state_t state, state_next;

  logic [CB-1:0]   mem [NUM_BINS];
  logic [CB-1:0]   rd_data;
  logic [CB-1:0]   count_in;
  logic [CB-1:0]   h_eff;
  logic            acc_in;

  logic [IB-1:0]   pos;
  logic [IB-1:0]   top;
  logic [NW-1:0]   total;
  logic [IB-1:0]   j;
  logic            pass2;

  logic [NW-1:0]   hj;
  logic [QW-1:0]   hjj;
  logic [SW-1:0]   s_all;
  logic [QW-1:0]   q_all;
  logic [NW-1:0]   n1;
  logic [SW-1:0]   s1;
  logic [QW-1:0]   q1;
  logic [NW-1:0]   n2;
  logic [SW-1:0]   s2;
  logic [QW-1:0]   q2;
  logic [DW-1:0]   nq;
  logic [DW-1:0]   d1;
  logic [DW-1:0]   d2;

  logic [DW-1:0]     x_sh;
  logic [EW-1:0]     e;
  logic [MANT_W-1:0] m;
  logic [FB-1:0]     frac;
  logic [KW-1:0]     k;
  logic [1:0]        lsel;
  logic [MANT_W:0]   sq;

  logic [AW-1:0]   a_sum;
  logic [AW-1:0]   b_sum;
  logic [AW-1:0]   b4;
  logic [AW-1:0]   best_a;
  logic [AW-1:0]   best_b;
  logic [AW:0]     lhs;
  logic [AW:0]     rhs;
  logic [AW-1:0]   nl_prod;
  logic [IB-1:0]   best_t;
  logic            found_r;

  logic            mul_is;
  logic            mul_start;
  logic            issued;
  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [PW-1:0]   mul_p;
  met_mul_sts_t    mul_sts;
  logic            out_take;

  // Shared multiplier
  met_mul #(.MW(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .sts   (mul_sts)
  );

  assign count_in  = CB'(bin_count[CIN-1:0]);
  assign in_stall  = (state != S_LOAD);
  assign acc_in    = in_valid && !in_stall;
  assign h_eff     = (pass2 && (j > top)) ? '0 : rd_data;
  assign n2        = total - n1;
  assign s2        = s_all - s1;
  assign q2        = q_all - q1;
  assign sq        = mul_p[2*MANT_W-1 -: MANT_W+1];
  assign nl_prod   = AW'(mul_p);
  assign b4        = b_sum << 2;
  assign lhs       = (AW+1)'(a_sum) + (AW+1)'(best_b);
  assign rhs       = (AW+1)'(best_a) + (AW+1)'(b4);
  assign mul_start = mul_is && !issued;
  assign out_take  = out_valid && !out_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operands
  always_comb begin
    state_next = state;
    mul_is     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_LOAD: begin
        if (acc_in && (last_bin || pos == IB'(NUM_BINS - 1))) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_MUL_HJ;
      end
      S_MUL_HJ: begin
        mul_is = 1'b1;
        mul_a  = MW'(h_eff);
        mul_b  = MW'(j);
        if (mul_sts.done) state_next = S_MUL_HJJ;
      end
      S_MUL_HJJ: begin
        mul_is = 1'b1;
        mul_a  = MW'(hj);
        mul_b  = MW'(j);
        if (mul_sts.done) state_next = S_ACC;
      end
      S_ACC: begin
        state_next = pass2 ? S_CHK1 : S_FETCH;
      end
      S_CHK1: begin
        state_next = (n1 == '0 || n2 == '0) ? S_NEXT : S_MUL_NQ1;
      end
      S_MUL_NQ1: begin
        mul_is = 1'b1;
        mul_a  = MW'(n1);
        mul_b  = MW'(q1);
        if (mul_sts.done) state_next = S_MUL_SS1;
      end
      S_MUL_SS1: begin
        mul_is = 1'b1;
        mul_a  = MW'(s1);
        mul_b  = MW'(s1);
        if (mul_sts.done) state_next = S_MUL_NQ2;
      end
      S_MUL_NQ2: begin
        mul_is = 1'b1;
        mul_a  = MW'(n2);
        mul_b  = MW'(q2);
        if (mul_sts.done) state_next = S_MUL_SS2;
      end
      S_MUL_SS2: begin
        mul_is = 1'b1;
        mul_a  = MW'(s2);
        mul_b  = MW'(s2);
        if (mul_sts.done) state_next = S_CHK2;
      end
      S_CHK2: begin
        state_next = (d1 == '0 || d2 == '0) ? S_NEXT : S_LOG_NORM;
      end
      S_LOG_NORM: begin
        if (x_sh[DW-1]) state_next = S_LOG_SQ;
      end
      S_LOG_SQ: begin
        mul_is = 1'b1;
        mul_a  = MW'(m);
        mul_b  = MW'(m);
        if (mul_sts.done && k == KW'(FB - 1)) state_next = S_MUL_NL;
      end
      S_MUL_NL: begin
        mul_is = 1'b1;
        mul_a  = (lsel == LOG_D2 || lsel == LOG_N2) ? MW'(n2) : MW'(n1);
        mul_b  = MW'({e, frac});
        if (mul_sts.done) begin
          state_next = (lsel == LOG_N2) ? S_CMP : S_LOG_NORM;
        end
      end
      S_CMP: begin
        state_next = S_NEXT;
      end
      S_NEXT: begin
        state_next = (j == IB'(NUM_BINS - 2)) ? S_OUT : S_FETCH;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Histogram store: write on load, read the current bin every cycle
  always_ff @(posedge clk) begin
    if (acc_in) begin
      mem[pos] <= count_in;
    end
    rd_data <= mem[j];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      total     <= '0;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // track the pending multiply
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_sts.done) begin
        issued <= 1'b0;
      end
      // advance the bin position and the running total
      if (acc_in) begin
        total <= total + NW'(count_in);
        if (last_bin || pos == IB'(NUM_BINS - 1)) begin
          pos <= '0;
        end else begin
          pos <= pos + IB'(1);
        end
      end
      // hand over the result, drop it once taken
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        total     <= '0;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (acc_in && (last_bin || pos == IB'(NUM_BINS - 1))) begin
          top     <= pos;
          j       <= '0;
          pass2   <= 1'b0;
          s_all   <= '0;
          q_all   <= '0;
          n1      <= '0;
          s1      <= '0;
          q1      <= '0;
          found_r <= 1'b0;
          best_t  <= '0;
          best_a  <= '0;
          best_b  <= '0;
        end
      end
      S_MUL_HJ: begin
        if (mul_sts.done) hj <= NW'(mul_p);
      end
      S_MUL_HJJ: begin
        if (mul_sts.done) hjj <= QW'(mul_p);
      end
      S_ACC: begin
        if (pass2) begin
          n1 <= n1 + NW'(h_eff);
          s1 <= s1 + SW'(hj);
          q1 <= q1 + hjj;
        end else begin
          s_all <= s_all + SW'(hj);
          q_all <= q_all + hjj;
          if (j == top) begin
            j     <= '0;
            pass2 <= 1'b1;
          end else begin
            j <= j + IB'(1);
          end
        end
      end
      S_MUL_NQ1, S_MUL_NQ2: begin
        if (mul_sts.done) nq <= DW'(mul_p);
      end
      S_MUL_SS1: begin
        if (mul_sts.done) d1 <= nq - DW'(mul_p);
      end
      S_MUL_SS2: begin
        if (mul_sts.done) d2 <= nq - DW'(mul_p);
      end
      S_CHK2: begin
        lsel <= LOG_D1;
        x_sh <= d1;
        e    <= EW'(DW - 1);
      end
      // normalize: shift a byte or a bit until the top bit is set
      S_LOG_NORM: begin
        if (x_sh[DW-1]) begin
          m    <= x_sh[DW-1 -: MANT_W];
          frac <= '0;
          k    <= '0;
        end else if (x_sh[DW-1 -: DIG_W] == '0) begin
          x_sh <= x_sh << DIG_W;
          e    <= e - EW'(DIG_W);
        end else begin
          x_sh <= x_sh << 1;
          e    <= e - EW'(1);
        end
      end
      // square the mantissa, emit one fraction bit
      S_LOG_SQ: begin
        if (mul_sts.done) begin
          k <= k + KW'(1);
          if (sq[MANT_W]) begin
            m    <= sq[MANT_W:1];
            frac <= {frac[FB-2:0], 1'b1};
          end else begin
            m    <= sq[MANT_W-1:0];
            frac <= {frac[FB-2:0], 1'b0};
          end
        end
      end
      // weight the log by the class count, load the next log operand
      S_MUL_NL: begin
        if (mul_sts.done) begin
          case (lsel)
            LOG_D1:  a_sum <= nl_prod;
            LOG_D2:  a_sum <= a_sum + nl_prod;
            LOG_N1:  b_sum <= nl_prod;
            default: b_sum <= b_sum + nl_prod;
          endcase
          lsel <= lsel + 2'd1;
          e    <= EW'(DW - 1);
          case (lsel)
            LOG_D1:  x_sh <= d2;
            LOG_D2:  x_sh <= DW'(n1);
            default: x_sh <= DW'(n2);
          endcase
        end
      end
      // keep the first smallest score
      S_CMP: begin
        if (!found_r || lhs < rhs) begin
          found_r <= 1'b1;
          best_a  <= a_sum;
          best_b  <= b4;
          best_t  <= j;
        end
      end
      S_NEXT: begin
        if (j != IB'(NUM_BINS - 2)) j <= j + IB'(1);
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          threshold       <= THR_W'(best_t);
          threshold_color <= {THR_W'(best_t), 8'h00};
          found           <= found_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  `MET_ASSERT_IMP(a_done_pending, clk, rst, mul_sts.done, issued && mul_is, "multiplier done with no pending operation")
  `MET_ASSERT_IMP(a_load_idle_mul, clk, rst, in_valid && !in_stall, !mul_sts.busy && !issued, "bin taken while multiplier busy")
  `MET_ASSERT_IMP(a_none_zero, clk, rst, out_valid && !found, threshold == '0 && threshold_color == '0, "no split but nonzero threshold")
  `MET_ASSERT_NEXT(a_out_load, clk, rst, state == S_OUT && !out_valid, out_valid, "result not loaded")

endmodule

`default_nettype wire

/* rtl/met_mul.sv */
// ---------------------------------------------------------------------------
// met_mul
// Shared digit-serial multiplier: one 8-bit digit of b per cycle, most
// significant digit first. The product holds after done until next start.
// ---------------------------------------------------------------------------
`default_nettype none

module met_mul #(
  parameter int MW = met_pkg::MUL_W_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [MW-1:0]         a,
  input  wire logic [MW-1:0]         b,
  output logic      [2*MW-1:0]       p,
  output met_pkg::met_mul_sts_t      sts
);
  import met_pkg::*;

  localparam int PW   = 2 * MW;
  localparam int NDIG = (MW + DIG_W - 1) / DIG_W;
  localparam int BPW  = NDIG * DIG_W;
  localparam int CNTW = $clog2(NDIG);

  logic [MW-1:0]       a_r;
  logic [BPW-1:0]      b_r;
  logic [PW-1:0]       acc;
  logic [CNTW-1:0]     cnt;
  logic                busy;
  logic                done;
  logic [MW+DIG_W-1:0] pp;
  logic [PW-1:0]       acc_next;

  // Partial product of the current top digit
  assign pp       = a_r * b_r[BPW-1 -: DIG_W];
  assign acc_next = (acc << DIG_W) + PW'(pp);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(NDIG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then accumulate one digit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= BPW'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      b_r <= b_r << DIG_W;
    end
  end

  assign p        = acc;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

`default_nettype wire

/* tb/sv/minimum_error_threshold_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// minimum_error_threshold_top_tb
// Sends gray histograms bin by bin, predicts the minimum-error split of each
// with an exact integer model and fixed-point logs, and checks every result
// against it while both channels idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module minimum_error_threshold_top_tb;

  localparam int NBINS    = met_pkg::NUM_BINS_DEF;
  localparam int FRAC     = met_pkg::LOG_FRAC_BITS_DEF;
  localparam int HOLD_LEN = 40000;

  typedef logic [127:0] wide_t;

  typedef struct packed {
    logic [met_pkg::THR_W-1:0]   thr;
    logic [met_pkg::COLOR_W-1:0] color;
    logic                        hit;
  } split_result_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [met_pkg::BIN_COUNT_W-1:0] bin_count;
  logic                            last_bin;
  logic                            out_valid;
  logic                            out_stall;
  logic [met_pkg::THR_W-1:0]       threshold;
  logic [met_pkg::COLOR_W-1:0]     threshold_color;
  logic                            found;

  // Model state
  logic [23:0]   hist_bins [NBINS];
  int unsigned   next_bin;
  split_result_t expected_splits [$];

  int  error_count;
  int  items_sent;
  bit  sender_idles;
  int  burst_left;
  int  pressure_req;
  int  pressure_ack;
  int  hold_left;
  int  stall_mode;

  minimum_error_threshold_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .bin_count       (bin_count),
    .last_bin        (last_bin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .threshold       (threshold),
    .threshold_color (threshold_color),
    .found           (found)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fixed-point base-2 log of x >= 1
  function automatic wide_t log2_fix(wide_t x);
    int          e;
    logic [63:0] m;
    wide_t       frac;
    e = 0;
    frac = '0;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) e = i;
    end
    if (e >= 31) begin
      m = 64'((x >> (e - 31)) & 128'hFFFF_FFFF);
    end else begin
      m = 64'(x << (31 - e));
    end
    for (int k = 0; k < FRAC; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 128'd1;
        m = m >> 1;
      end
    end
    return (wide_t'(e) << FRAC) | frac;
  endfunction

  // Score every split up to NBINS-2, bins above top taken as empty, and keep the first minimum
  function automatic split_result_t min_error_split(int unsigned top);
    wide_t         n_all, s_all, q_all, n1, s1, q1, n2, s2, q2;
    wide_t         d1, d2, a, b, best_a, best_b, h, j;
    int unsigned   best_t;
    bit            hit;
    split_result_t r;
    n_all = '0; s_all = '0; q_all = '0;
    n1 = '0; s1 = '0; q1 = '0;
    best_a = '0; best_b = '0;
    best_t = 0;
    hit = 1'b0;
    for (int unsigned i = 0; i <= top && i < NBINS; i++) begin
      h = wide_t'(hist_bins[i]);
      j = wide_t'(i);
      n_all += h;
      s_all += h * j;
      q_all += h * j * j;
    end
    for (int unsigned t = 0; t + 1 < NBINS; t++) begin
      h = (t <= top) ? wide_t'(hist_bins[t]) : '0;
      j = wide_t'(t);
      n1 += h;
      s1 += h * j;
      q1 += h * j * j;
      n2 = n_all - n1;
      s2 = s_all - s1;
      q2 = q_all - q1;
      if (n1 == 0 || n2 == 0) continue;
      d1 = n1 * q1 - s1 * s1;
      d2 = n2 * q2 - s2 * s2;
      if (d1 == 0 || d2 == 0) continue;
      a = n1 * log2_fix(d1) + n2 * log2_fix(d2);
      b = 4 * (n1 * log2_fix(n1) + n2 * log2_fix(n2));
      if (!hit || (a + best_b < best_a + b)) begin
        hit = 1'b1;
        best_a = a;
        best_b = b;
        best_t = t;
      end
    end
    r.thr   = best_t[7:0];
    r.color = 16'(best_t << 8);
    r.hit   = hit;
    return r;
  endfunction

  // Store one accepted bin and queue the result of a finished histogram
  function automatic void take_bin(logic [23:0] cnt, logic lst);
    int unsigned pos;
    pos = (next_bin >= NBINS) ? 0 : next_bin;
    hist_bins[pos] = cnt;
    if (lst || pos + 1 >= NBINS) begin
      expected_splits.push_back(min_error_split(pos));
      next_bin = 0;
    end else begin
      next_bin = pos + 1;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Offer one item and wait for it to be taken, then, if sender_idles is set, idle in bursts
  task automatic send_bin(logic [23:0] cnt, logic lst);
    bit stalled;
    int gap;
    in_valid  <= 1'b1;
    bin_count <= cnt;
    last_bin  <= lst;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    take_bin(cnt, lst);
    items_sent++;
    if (sender_idles) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_count();
    case ($urandom_range(0, 4))
      0:       return 24'd0;
      1:       return 24'($urandom_range(0, 15));
      2:       return 24'($urandom_range(0, 4095));
      3:       return 24'($urandom);
      default: return 24'hFF_FFFF;
    endcase
  endfunction

  task automatic send_histogram(int len);
    for (int i = 0; i < len; i++) send_bin(pick_count(), i == len - 1);
  endtask

  // Lone bin, empty histogram and two full-scale bins all have no valid split
  task automatic test_no_split();
    send_bin(24'd0, 1'b1);
    send_bin(24'hFF_FFFF, 1'b1);
    send_bin(24'd0, 1'b0);
    send_bin(24'd0, 1'b0);
    send_bin(24'd0, 1'b1);
    send_bin(24'hFF_FFFF, 1'b0);
    send_bin(24'hFF_FFFF, 1'b1);
  endtask

  // Two spread-out modes, small and full-scale
  task automatic test_bimodal();
    send_bin(24'd5, 1'b0);
    send_bin(24'd9, 1'b0);
    send_bin(24'd0, 1'b0);
    send_bin(24'd1, 1'b0);
    send_bin(24'd7, 1'b0);
    send_bin(24'd3, 1'b1);
    send_bin(24'hFF_FFFF, 1'b0);
    send_bin(24'h80_0000, 1'b0);
    send_bin(24'd1, 1'b0);
    send_bin(24'h55_5555, 1'b0);
    send_bin(24'hAA_AAAA, 1'b0);
    send_bin(24'hFF_FFFF, 1'b1);
  endtask

  // Full-length histogram without the flag: the final bin ends it
  task automatic test_full_length();
    for (int i = 0; i < NBINS; i++) send_bin(pick_count(), 1'b0);
  endtask

  // Hold the output for a long stretch while short histograms keep coming
  task automatic test_output_hold();
    pressure_req <= pressure_req + 1;
    for (int k = 0; k < 4; k++) send_histogram($urandom_range(2, 5));
  endtask

  task automatic test_random();
    while (items_sent < 700) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      stall_mode   = $urandom_range(0, 2);
      send_histogram($urandom_range(2, 24));
    end
  endtask

  // Receiver stall pattern, with a counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (pressure_req != pressure_ack) begin
      pressure_ack = pressure_req;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Check each accepted result against the oldest expectation
  always @(negedge clk) begin
    split_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_splits.size() == 0) begin
        report_mismatch("result with no histogram pending");
      end else begin
        want = expected_splits.pop_front();
        if (threshold !== want.thr)
          report_mismatch($sformatf("threshold %0d, want %0d", threshold, want.thr));
        if (threshold_color !== want.color)
          report_mismatch($sformatf("threshold_color %0h, want %0h",
                                    threshold_color, want.color));
        if (found !== want.hit)
          report_mismatch($sformatf("found %0b, want %0b", found, want.hit));
      end
    end
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    bin_count    = '0;
    last_bin     = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    next_bin     = 0;
    sender_idles = 1'b0;
    burst_left   = 0;
    pressure_req = 0;
    pressure_ack = 0;
    hold_left    = 0;
    stall_mode   = 0;
    for (int i = 0; i < NBINS; i++) hist_bins[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_split();
    stall_mode   = 1;
    sender_idles = 1'b1;
    test_bimodal();
    test_full_length();
    test_output_hold();
    test_random();
    wait_idle();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
